// ----- rtl/rq_pkg.sv -----
// rq_pkg: shared widths, register indexes and the divider cell payload type
// for the range quantizer. No dependencies.

package rq_pkg;

    localparam int DATA_W    = 32;             // Q16.16 sample and bounds
    localparam int LEVEL_W   = 31;             // widest quantized level
    localparam int BITS_W    = 5;              // level_bits register
    localparam int DEN_W     = DATA_W;         // range span, unsigned
    localparam int DIVR_W    = DEN_W + 1;      // divisor 2*den
    localparam int REM_W     = DIVR_W;         // partial remainder
    localparam int PROD_W    = DEN_W + LEVEL_W;
    localparam int DVD_W     = PROD_W + 1;     // dividend 2*num*top + den
    localparam int NUM_CELLS = LEVEL_W;        // one quotient bit per cell
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_BITS = 2'd2;

    // reset values
    localparam logic [DATA_W-1:0] RANGE_LOW_RST  = 32'h0000_0000;
    localparam logic [DATA_W-1:0] RANGE_HIGH_RST = 32'h0001_0000;
    localparam logic [BITS_W-1:0] LEVEL_BITS_RST = 5'd16;

    // payload handed from cell to cell in the divider chain
    typedef struct packed {
        logic                 err;   // range_high <= range_low
        logic [REM_W-1:0]     rem;   // partial remainder, below the divisor
        logic [LEVEL_W-1:0]   low;   // dividend bits not yet shifted in
        logic [LEVEL_W-1:0]   quot;  // quotient bits developed so far
    } rq_cell_t;

endpackage

// ----- rtl/rq_front.sv -----
// rq_front: clamp, span offset, scale by the top level and form the dividend.
// Three register stages. Depends on rq_pkg.

module rq_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic signed [rq_pkg::DATA_W-1:0]  sample,
    input  logic signed [rq_pkg::DATA_W-1:0]  range_low,
    input  logic signed [rq_pkg::DATA_W-1:0]  range_high,
    input  logic [rq_pkg::LEVEL_W-1:0]   top,
    input  logic [rq_pkg::DEN_W-1:0]     den,
    output logic                         out_valid,
    output rq_pkg::rq_cell_t             out_data
);
    import rq_pkg::*;

    // stage A: clamp and offset
    logic                  a_valid_reg;
    logic                  a_err_reg, a_err_next;
    logic [DEN_W-1:0]      num_reg, num_next;
    logic signed [DATA_W-1:0] clamped;
    logic [DATA_W:0]       diff;

    // stage B: scale
    logic                  b_valid_reg;
    logic                  b_err_reg;
    logic [PROD_W-1:0]     prod_reg, prod_next;

    // stage C: dividend
    logic                  c_valid_reg;
    rq_cell_t              c_data_reg, c_data_next;
    logic [DVD_W-1:0]      dvd;

    always_comb
    begin
        if (sample < range_low)
            clamped = range_low;
        else if (sample > range_high)
            clamped = range_high;
        else
            clamped = sample;
        diff       = {clamped[DATA_W-1], clamped} - {range_low[DATA_W-1], range_low};
        num_next   = diff[DEN_W-1:0];
        a_err_next = (range_high <= range_low);
    end

    assign prod_next = {{LEVEL_W{1'b0}}, num_reg} * {{DEN_W{1'b0}}, top};

    always_comb
    begin
        dvd              = {prod_reg, 1'b0} + {{(DVD_W-DEN_W){1'b0}}, den};
        c_data_next.err  = b_err_reg;
        c_data_next.rem  = dvd[DVD_W-1:LEVEL_W];
        c_data_next.low  = dvd[LEVEL_W-1:0];
        c_data_next.quot = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg    <= num_next;
        a_err_reg  <= a_err_next;
        prod_reg   <= prod_next;
        b_err_reg  <= a_err_reg;
        c_data_reg <= c_data_next;
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_data_reg;

endmodule

// ----- rtl/rq_div_cell.sv -----
// rq_div_cell: one restoring-division step, one quotient bit per cell.
// Depends on rq_pkg.

module rq_div_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rq_pkg::DIVR_W-1:0]   divisor,
    input  logic                        in_valid,
    input  rq_pkg::rq_cell_t            in_data,
    output logic                        out_valid,
    output rq_pkg::rq_cell_t            out_data
);
    import rq_pkg::*;

    logic                 valid_reg;
    rq_cell_t             data_reg, data_next;
    logic [REM_W:0]       trial;
    logic [REM_W+1:0]     diff;
    logic                 qbit;

    always_comb
    begin
        // shift in the next dividend bit, subtract when it fits
        trial = {in_data.rem, in_data.low[LEVEL_W-1]};
        diff  = {1'b0, trial} - {2'b00, divisor};
        qbit  = ~diff[REM_W+1];

        data_next.err  = in_data.err;
        data_next.rem  = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
        data_next.low  = {in_data.low[LEVEL_W-2:0], 1'b0};
        data_next.quot = {in_data.quot[LEVEL_W-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/range_quantizer_core.sv -----
// range_quantizer_core: linear range quantizer, one level per Q16.16 sample.
// Pipeline: three front stages (clamp, scale, dividend) and 31 division cells.
// Throughput one sample per cycle; busy stays low and the receiver cannot stall.
// Reset (rst_n low, asynchronous) drops all transactions in flight and loads
// range_low = 0, range_high = 1.0, level_bits = 16.
// Depends on rq_pkg, rq_front and rq_div_cell.

module range_quantizer_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_write,
    input  logic [rq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rq_pkg::DATA_W-1:0]         cfg_data,
    // sample command
    input  logic                              start,
    output logic                              busy,
    input  logic signed [rq_pkg::DATA_W-1:0]  sample,
    // result, one cycle per transaction
    output logic                              done,
    output logic [rq_pkg::LEVEL_W-1:0]        level,
    output logic                              range_error
);
    import rq_pkg::*;

    // configuration registers; the user must change them only while no transaction is
    // in flight (the block does not enforce this), so every stage reads them directly
    logic signed [DATA_W-1:0] range_low_reg, range_low_next;
    logic signed [DATA_W-1:0] range_high_reg, range_high_next;
    logic [BITS_W-1:0]        level_bits_reg, level_bits_next;

    logic [DATA_W-1:0]        top_wide;
    logic [LEVEL_W-1:0]       top;
    logic [DATA_W-1:0]        span;
    logic [DEN_W-1:0]         den;
    logic [DIVR_W-1:0]        divisor;

    logic                     chain_valid [0:NUM_CELLS];
    rq_cell_t                 chain_data  [0:NUM_CELLS];

    always_comb
    begin
        range_low_next  = range_low_reg;
        range_high_next = range_high_reg;
        level_bits_next = level_bits_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_RANGE_LOW:  range_low_next  = cfg_data;
                REG_RANGE_HIGH: range_high_next = cfg_data;
                REG_LEVEL_BITS: level_bits_next = cfg_data[BITS_W-1:0];
                default:        ; // drop writes to unmapped indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= RANGE_LOW_RST;
            range_high_reg <= RANGE_HIGH_RST;
            level_bits_reg <= LEVEL_BITS_RST;
        end
        else
        begin
            range_low_reg  <= range_low_next;
            range_high_reg <= range_high_next;
            level_bits_reg <= level_bits_next;
        end
    end

    // top level 2^bits - 1, span and divisor 2*span; span is only meaningful
    // for a valid range, an invalid one forces the level to zero at the end
    assign top_wide = (32'd1 << level_bits_reg) - 32'd1;
    assign top      = top_wide[LEVEL_W-1:0];
    assign span     = range_high_reg - range_low_reg;
    assign den      = span;
    assign divisor  = {den, 1'b0};

    // every sample is taken; the pipeline never holds off a command
    assign busy = 1'b0;

    rq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .sample     (sample),
        .range_low  (range_low_reg),
        .range_high (range_high_reg),
        .top        (top),
        .den        (den),
        .out_valid  (chain_valid[0]),
        .out_data   (chain_data[0])
    );

    // division chain: each cell develops one quotient bit, MSB first
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        rq_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .divisor   (divisor),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // present the finished transaction straight from the last cell
    assign done        = chain_valid[NUM_CELLS];
    assign range_error = chain_data[NUM_CELLS].err;
    assign level       = chain_data[NUM_CELLS].err ? '0 : chain_data[NUM_CELLS].quot;

endmodule
